// ----- rtl/pba_pkg.sv -----
// ---------------------------------------------------------------------------
// pba_pkg
// Shared constants, codes and types for the page bitmap allocator.
// ---------------------------------------------------------------------------
package pba_pkg;

    // Map geometry
    localparam int MAP_PAGES  = 16384;
    localparam int PAGE_BYTES = 4096;
    localparam int WORD_BITS  = 64;
    localparam int NUM_WORDS  = MAP_PAGES / WORD_BITS;

    localparam int PB_SH   = $clog2(PAGE_BYTES);
    localparam int WBIT_W  = $clog2(WORD_BITS);
    localparam int WADDR_W = $clog2(NUM_WORDS);
    localparam int PAGE_W  = $clog2(MAP_PAGES);
    localparam int CNT_W   = $clog2(MAP_PAGES + 1);

    // Field widths
    localparam int FUNC_W   = 1;
    localparam int N_W      = 15;
    localparam int ADDR_W   = 26;
    localparam int STATUS_W = 2;
    localparam int START_W  = 14;
    localparam int OFFS_W   = 26;
    localparam int FB_W     = 27;
    localparam int LIVE_W   = 15;

    // Sum of a page index and a page count, one spare bit
    localparam int SUM_W = ((PAGE_W > N_W) ? PAGE_W : N_W) + 1;

    // Stream payload widths, rounded up to bytes
    localparam int S_BITS      = N_W + ADDR_W;
    localparam int S_TDATA_W   = ((S_BITS + 7) / 8) * 8;
    localparam int M_BITS      = STATUS_W + START_W + OFFS_W + FB_W + LIVE_W;
    localparam int M_TDATA_W   = ((M_BITS + 7) / 8) * 8;

    localparam logic [FB_W-1:0]   TOTAL_BYTES = FB_W'(MAP_PAGES * PAGE_BYTES);
    localparam logic [LIVE_W-1:0] LIVE_MAX    = '1;

    // Request kinds
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NO_RUN    = 2'd1,
        STATUS_BAD_COUNT = 2'd2
    } t_status;

    // Segment unit result
    typedef struct packed {
        logic                 hit;
        logic [WBIT_W:0]      used_cnt;
        logic [CNT_W-1:0]     seg_end;
        logic [WORD_BITS-1:0] mask;
    } t_seg_res;

endpackage

// ----- rtl/pba_bitmap_ram.sv -----
// ---------------------------------------------------------------------------
// pba_bitmap_ram
// Used-page map: one word of page bits per row, registered read, one write
// port. A row valid bit per word makes unwritten rows read as all free.
// ---------------------------------------------------------------------------
module pba_bitmap_ram
    import pba_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_rd_en,
    input  logic [WADDR_W-1:0]   i_rd_addr,
    output logic [WORD_BITS-1:0] o_rd_data,
    input  logic                 i_wr_en,
    input  logic [WADDR_W-1:0]   i_wr_addr,
    input  logic [WORD_BITS-1:0] i_wr_data
);

    logic [WORD_BITS-1:0] r_mem [NUM_WORDS];
    logic [NUM_WORDS-1:0] r_row_valid;
    logic [WORD_BITS-1:0] r_rd_data;
    logic                 r_rd_valid;

    // Storage array
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // Row valid bits, cleared at once by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
            r_rd_valid  <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_row_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_row_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

// ----- rtl/pba_seg_unit.sv -----
// ---------------------------------------------------------------------------
// pba_seg_unit
// Shared segment unit: masks the part of one map word between the current
// page and the run end, tests it for used pages and counts them.
// ---------------------------------------------------------------------------
module pba_seg_unit
    import pba_pkg::*;
(
    input  logic [WORD_BITS-1:0] i_word,
    input  logic [CNT_W-1:0]     i_pos,
    input  logic [CNT_W-1:0]     i_end,
    output t_seg_res             o_res
);

    logic [CNT_W-1:0]     base;
    logic [CNT_W-1:0]     word_end;
    logic [CNT_W-1:0]     seg_end;
    logic [WBIT_W:0]      hi_cnt;
    logic [WBIT_W-1:0]    lo;
    logic [WORD_BITS-1:0] mask;
    logic [WORD_BITS-1:0] sel;

    // Segment bounds inside the word
    always_comb begin
        base     = {i_pos[CNT_W-1:WBIT_W], WBIT_W'(0)};
        word_end = base + CNT_W'(WORD_BITS);
        seg_end  = (i_end < word_end) ? i_end : word_end;
        hi_cnt   = (WBIT_W + 1)'(seg_end - base);
        lo       = i_pos[WBIT_W-1:0];
    end

    // Bit mask, used test and used count
    always_comb begin
        mask = ~({WORD_BITS{1'b1}} << hi_cnt) & ({WORD_BITS{1'b1}} << lo);
        sel  = i_word & mask;
        o_res.hit      = |sel;
        o_res.used_cnt = (WBIT_W + 1)'($countones(sel));
        o_res.seg_end  = seg_end;
        o_res.mask     = mask;
    end

endmodule

// ----- rtl/page_bitmap_allocator.sv -----
// ---------------------------------------------------------------------------
// page_bitmap_allocator
// First-fit page allocator over a used-page bitmap held in a word memory.
// ---------------------------------------------------------------------------
// Flow: a bad allocate count, an empty free or a free that starts past the
//   map goes straight to the result state. Otherwise each map word segment
//   visited takes a memory read, then a test or update in the shared segment
//   unit: an allocate searches segments, then marks each word of the run;
//   a free clears each word of its range.
// Throughput: one request at a time; ready returns once the result beat is
//   loaded into the output register. Reset clears control state and the
//   row valid bits of the map at once; no clearing pass is needed.
module page_bitmap_allocator
    import pba_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Request stream
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,  // page_count[14:0], free_address[40:15]
    input  logic                 i_s_tuser,  // func[0]
    // Result stream
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata   // status[1:0], start_page[15:2],
                                             // byte_offset[41:16], free_bytes[68:42],
                                             // live_allocations[83:69]
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_SRD  = 6'b000010,
        ST_SCHK = 6'b000100,
        ST_MRD  = 6'b001000,
        ST_MWR  = 6'b010000,
        ST_DONE = 6'b100000
    } t_state;

    t_state               r_state, n_state;
    logic                 r_func, n_func;
    logic [N_W-1:0]       r_n, n_n;
    logic [PAGE_W-1:0]    r_cand, n_cand;
    logic [CNT_W-1:0]     r_pos, n_pos;
    logic [CNT_W-1:0]     r_end, n_end;
    logic [FB_W-1:0]      r_free_total, n_free_total;
    logic [LIVE_W-1:0]    r_live, n_live;
    t_status              r_status, n_status;
    logic [START_W-1:0]   r_start, n_start;
    logic [OFFS_W-1:0]    r_offset, n_offset;
    logic                 r_out_valid, n_out_valid;
    logic [M_TDATA_W-1:0] r_out_data;

    logic [WORD_BITS-1:0] rd_data;
    logic [WORD_BITS-1:0] wr_data;
    logic                 ram_rd_en;
    logic                 ram_wr_en;
    logic [WADDR_W-1:0]   word_addr;
    t_seg_res             seg;

    logic                 in_func;
    logic [N_W-1:0]       in_n;
    logic [SUM_W-1:0]     in_first;
    logic [SUM_W-1:0]     in_free_end;
    logic [SUM_W-1:0]     next_cand;
    logic [SUM_W-1:0]     next_end;
    logic                 out_load;
    logic [LIVE_W-1:0]    live_inc;
    logic [LIVE_W-1:0]    live_dec;

    // Bitmap memory and shared segment unit
    assign word_addr = r_pos[PAGE_W-1:WBIT_W];
    assign ram_rd_en = (r_state == ST_SRD) || (r_state == ST_MRD);
    assign ram_wr_en = (r_state == ST_MWR);
    assign wr_data   = (r_func == FUNC_ALLOC) ? (rd_data | seg.mask) : (rd_data & ~seg.mask);

    pba_bitmap_ram u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (word_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (word_addr),
        .i_wr_data (wr_data)
    );

    pba_seg_unit u_seg (
        .i_word (rd_data),
        .i_pos  (r_pos),
        .i_end  (r_end),
        .o_res  (seg)
    );

    // Request fields and helper sums
    always_comb begin
        in_func     = i_s_tuser;
        in_n        = i_s_tdata[N_W-1:0];
        in_first    = SUM_W'(i_s_tdata[N_W+ADDR_W-1:N_W+PB_SH]);
        in_free_end = in_first + SUM_W'(in_n);
        next_cand   = SUM_W'(r_cand) + SUM_W'(r_n);
        next_end    = next_cand + SUM_W'(r_n);
        live_inc    = (r_live == LIVE_MAX) ? r_live : r_live + LIVE_W'(1);
        live_dec    = (r_live == '0) ? r_live : r_live - LIVE_W'(1);
        out_load    = (r_state == ST_DONE) && (!r_out_valid || i_m_tready);
    end

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_func       = r_func;
        n_n          = r_n;
        n_cand       = r_cand;
        n_pos        = r_pos;
        n_end        = r_end;
        n_free_total = r_free_total;
        n_live       = r_live;
        n_status     = r_status;
        n_start      = r_start;
        n_offset     = r_offset;
        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_func   = in_func;
                    n_n      = in_n;
                    n_status = STATUS_OK;
                    n_start  = '0;
                    n_offset = '0;
                    if (in_func == FUNC_ALLOC) begin
                        if (in_n == '0 || in_n > N_W'(MAP_PAGES)) begin
                            n_status = STATUS_BAD_COUNT;
                            n_state  = ST_DONE;
                        end else begin
                            n_cand  = '0;
                            n_pos   = '0;
                            n_end   = CNT_W'(in_n);
                            n_state = ST_SRD;
                        end
                    end else begin
                        if (in_n == '0 || in_first >= SUM_W'(MAP_PAGES)) begin
                            n_live  = live_dec;
                            n_state = ST_DONE;
                        end else begin
                            n_pos   = CNT_W'(in_first);
                            n_end   = (in_free_end >= SUM_W'(MAP_PAGES)) ?
                                      CNT_W'(MAP_PAGES) : CNT_W'(in_free_end);
                            n_state = ST_MRD;
                        end
                    end
                end
            end
            ST_SRD: begin
                n_state = ST_SCHK;
            end
            ST_SCHK: begin
                if (seg.hit) begin
                    // Candidate fails: step to the next aligned start
                    if (next_end > SUM_W'(MAP_PAGES)) begin
                        n_status = STATUS_NO_RUN;
                        n_state  = ST_DONE;
                    end else begin
                        n_cand  = PAGE_W'(next_cand);
                        n_pos   = CNT_W'(next_cand);
                        n_end   = CNT_W'(next_end);
                        n_state = ST_SRD;
                    end
                end else if (seg.seg_end == r_end) begin
                    // Whole run free: go back and mark it
                    n_pos   = CNT_W'(r_cand);
                    n_state = ST_MRD;
                end else begin
                    n_pos   = seg.seg_end;
                    n_state = ST_SRD;
                end
            end
            ST_MRD: begin
                n_state = ST_MWR;
            end
            ST_MWR: begin
                if (r_func == FUNC_FREE) begin
                    n_free_total = r_free_total + (FB_W'(seg.used_cnt) << PB_SH);
                end
                n_pos = seg.seg_end;
                if (seg.seg_end == r_end) begin
                    if (r_func == FUNC_ALLOC) begin
                        n_free_total = r_free_total - (FB_W'(r_n) << PB_SH);
                        n_live       = live_inc;
                        n_start      = START_W'(r_cand);
                        n_offset     = OFFS_W'(r_cand) << PB_SH;
                    end else begin
                        n_live = live_dec;
                    end
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_MRD;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Output register valid
    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_free_total <= TOTAL_BYTES;
            r_live       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_free_total <= n_free_total;
            r_live       <= n_live;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_func   <= n_func;
        r_n      <= n_n;
        r_cand   <= n_cand;
        r_pos    <= n_pos;
        r_end    <= n_end;
        r_status <= n_status;
        r_start  <= n_start;
        r_offset <= n_offset;
        if (out_load) begin
            r_out_data <= {(M_TDATA_W - M_BITS)'(0), r_live, r_free_total,
                           r_offset, r_start, r_status};
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // Checks
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_total <= TOTAL_BYTES)
        else $error("free byte total above map size");

    a_search_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SRD || r_state == ST_SCHK) |->
        (CNT_W'(r_cand) <= r_pos && r_pos < r_end && r_end <= CNT_W'(MAP_PAGES)))
        else $error("search position outside candidate run");

    a_update_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_wr_en |-> (r_pos < r_end && r_end <= CNT_W'(MAP_PAGES)))
        else $error("map update outside request range");

    a_result_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (r_out_valid && r_state == ST_IDLE))
        else $error("result beat not presented after load");

endmodule
